>>> design/fvol_pkg.sv
// Shared types and constants for the float-voltage offset learner.
// Holds the field widths, the register index codes and the sequencer state type.
// No dependencies.
`default_nettype none

package fvol_pkg;

	localparam int MV_W       = 16;
	localparam int TIME_W     = 32;
	localparam int SUM_W      = 40;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLOAT_REF    = 3'd0,
		REG_CAL_LIMIT    = 3'd1,
		REG_CLIMB_RISE   = 3'd2,
		REG_PLAT_SPREAD  = 3'd3,
		REG_PLAT_HOLD    = 3'd4
	} fvol_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WINDOW,
		ST_DIV_LAUNCH,
		ST_DIV_WAIT,
		ST_EMIT
	} fvol_state_t;

endpackage

`default_nettype wire

>>> design/fvol_div.sv
// Iterative restoring divider: one quotient bit per cycle, keeps the low quotient bits.
// Generic, no package dependency.
`default_nettype none

module fvol_div #(
	parameter int DIVIDEND_W = 41,
	parameter int DIVISOR_W  = 24,
	parameter int QUOT_W     = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [QUOT_W-1:0]          quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [QUOT_W-1:0]     quo_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;
	logic [DIVISOR_W:0]    rem_next;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, dvd_q[DIVIDEND_W-1]};
		fits     = trial >= {1'b0, divisor};
		rem_next = fits ? (trial - {1'b0, divisor}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= rem_next[DIVISOR_W-1:0];
			quo_q <= {quo_q[QUOT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> design/float_voltage_offset_learner_top.sv
// Float-voltage offset learner: one battery sample in, one offset result out.
// Each accepted sample is latched, checked in ST_CHECK and, when it extends an open
// window, handled in ST_WINDOW; a complete window is averaged by the divider (41 steps).
// The next sample is accepted only once the sequencer is back in idle; a stalled
// result holds the sequencer in its emit state. Reset (arst_n, async, active low) clears
// session, window and learned flags and loads the register defaults.
`default_nettype none

module float_voltage_offset_learner_top
	import fvol_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// sample channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  on_external_power,
	input  wire logic [MV_W-1:0]       battery_mv,
	input  wire logic [TIME_W-1:0]     time_ms,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [MV_W-1:0]     offset_mv,
	output logic                       offset_valid,
	output logic                       offset_updated,
	// register writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// dividend carries the 40-bit sum plus half the count for rounding
	localparam int DIV_W = SUM_W + 1;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [MV_W-1:0]   ref_q;
	logic [MV_W-1:0]   limit_q;
	logic [MV_W-1:0]   climb_q;
	logic [MV_W-1:0]   spread_q;
	logic [TIME_W-1:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q    <= MV_W'(4200);
			limit_q  <= MV_W'(200);
			climb_q  <= MV_W'(100);
			spread_q <= MV_W'(20);
			hold_q   <= TIME_W'(60000);
		end else if (cfg_we) begin
			// unknown indexes fall through and change nothing
			unique case (fvol_reg_t'(cfg_index))
				REG_FLOAT_REF:   ref_q    <= cfg_data[MV_W-1:0];
				REG_CAL_LIMIT:   limit_q  <= cfg_data[MV_W-1:0];
				REG_CLIMB_RISE:  climb_q  <= cfg_data[MV_W-1:0];
				REG_PLAT_SPREAD: spread_q <= cfg_data[MV_W-1:0];
				REG_PLAT_HOLD:   hold_q   <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// State
	// ---------------------------------------------------------------
	fvol_state_t state_q, state_d;

	// latched sample
	logic              pwr_q;
	logic [MV_W-1:0]   mv_q;
	logic [TIME_W-1:0] t_q;

	// session and window
	logic                   cabled_q;
	logic                   holding_q;
	logic [MV_W-1:0]        session_low_q;
	logic [TIME_W-1:0]      win_start_q;
	logic [SUM_W-1:0]       win_sum_q;
	logic [COUNT_WIDTH-1:0] win_count_q;
	logic [MV_W-1:0]        win_low_q;
	logic [MV_W-1:0]        win_high_q;

	// learned result
	logic [MV_W-1:0] learned_offset_q;
	logic            learned_flag_q;
	logic            updated_q;

	// output register
	logic            out_valid_q;
	logic [MV_W-1:0] out_offset_q;
	logic            out_flag_q;
	logic            out_updated_q;

	// sequencer controls
	logic div_start;
	logic out_load;

	// divider
	logic             div_done;
	logic [MV_W-1:0]  div_quot;
	logic [DIV_W-1:0] div_dividend;

	// ---------------------------------------------------------------
	// Sample classification (valid in ST_CHECK / ST_WINDOW)
	// ---------------------------------------------------------------
	logic              below_low;
	logic              climbed;
	logic              in_band;
	logic              check_ok;
	logic [MV_W-1:0]   spread_now;
	logic              spread_bad;
	logic [TIME_W-1:0] elapsed;
	logic              hold_done;
	logic              count_full;
	logic              win_open;

	always_comb begin
		below_low  = mv_q < session_low_q;
		// mv >= session_low here, so the difference cannot wrap
		climbed    = (mv_q - session_low_q) >= climb_q;
		in_band    = (({1'b0, mv_q} + {1'b0, limit_q}) >= {1'b0, ref_q}) &&
		             ({1'b0, mv_q} <= ({1'b0, ref_q} + {1'b0, limit_q}));
		check_ok   = pwr_q && cabled_q && !below_low && climbed && in_band;
		spread_now = win_high_q - win_low_q;
		spread_bad = spread_now > spread_q;
		// timestamps wrap, so the elapsed time is taken modulo 2^32
		elapsed    = t_q - win_start_q;
		hold_done  = elapsed >= hold_q;
		count_full = win_count_q == {COUNT_WIDTH{1'b1}};
		// a fresh window starts on the first qualifying sample, on a spread
		// violation, and right after an offset is learned
		win_open   = ((state_q == ST_CHECK) && check_ok && !holding_q) ||
		             ((state_q == ST_WINDOW) && spread_bad) ||
		             ((state_q == ST_DIV_WAIT) && div_done);
		div_dividend = {1'b0, win_sum_q} +
		               {{(DIV_W - COUNT_WIDTH){1'b0}}, win_count_q >> 1};
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_valid) state_d = ST_CHECK;
			ST_CHECK:      state_d = (check_ok && holding_q) ? ST_WINDOW : ST_EMIT;
			ST_WINDOW:     state_d = (!spread_bad && hold_done) ? ST_DIV_LAUNCH : ST_EMIT;
			ST_DIV_LAUNCH: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:   if (div_done) state_d = ST_EMIT;
			ST_EMIT:       if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == ST_IDLE;
		div_start = state_q == ST_DIV_LAUNCH;
		// hand the result over once the output register is free
		out_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			cabled_q         <= 1'b0;
			holding_q        <= 1'b0;
			learned_offset_q <= '0;
			learned_flag_q   <= 1'b0;
			updated_q        <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				updated_q <= 1'b0;
			end
			if (state_q == ST_CHECK) begin
				// power loss drops the session; any failed check drops the window
				cabled_q  <= pwr_q;
				holding_q <= check_ok;
			end
			if ((state_q == ST_DIV_WAIT) && div_done) begin
				learned_offset_q <= ref_q - div_quot;
				learned_flag_q   <= 1'b1;
				updated_q        <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pwr_q <= on_external_power;
			mv_q  <= battery_mv;
			t_q   <= time_ms;
		end

		// new session low on the first cabled sample or a deeper dip
		if ((state_q == ST_CHECK) && pwr_q && (!cabled_q || below_low)) begin
			session_low_q <= mv_q;
		end

		if (win_open) begin
			win_start_q <= t_q;
			win_sum_q   <= {{(SUM_W - MV_W){1'b0}}, mv_q};
			win_count_q <= COUNT_WIDTH'(1);
			win_low_q   <= mv_q;
			win_high_q  <= mv_q;
		end else if ((state_q == ST_CHECK) && check_ok) begin
			// window continues: widen its range
			if (mv_q < win_low_q) begin
				win_low_q <= mv_q;
			end
			if (mv_q > win_high_q) begin
				win_high_q <= mv_q;
			end
		end else if ((state_q == ST_WINDOW) && !count_full) begin
			// saturated count freezes sum and count
			win_sum_q   <= win_sum_q + {{(SUM_W - MV_W){1'b0}}, mv_q};
			win_count_q <= win_count_q + COUNT_WIDTH'(1);
		end

		if (out_load) begin
			out_offset_q  <= learned_offset_q;
			out_flag_q    <= learned_flag_q;
			out_updated_q <= updated_q;
		end
	end

	// ---------------------------------------------------------------
	// Rounded average: (sum + count/2) / count
	// ---------------------------------------------------------------
	fvol_div #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (COUNT_WIDTH),
		.QUOT_W     (MV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (win_count_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_valid      = out_valid_q;
	assign offset_mv      = out_offset_q;
	assign offset_valid   = out_flag_q;
	assign offset_updated = out_updated_q;

`ifndef SYNTHESIS
	// divider completes only while the sequencer waits for it
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	// a window only exists inside a cabled session
	a_holding_cabled: assert property (@(posedge clk) disable iff (!arst_n)
		holding_q |-> cabled_q)
		else $error("window open without external power session");

	// a finished division always marks the offset learned and updated
	a_learn_marks: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV_WAIT) && div_done) |=> (learned_flag_q && updated_q))
		else $error("learned offset not flagged");

	// the divisor is never zero when a division is launched
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_LAUNCH) |-> (win_count_q != '0))
		else $error("window count zero at division");
`endif

endmodule

`default_nettype wire
